>>> hdl/plct_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plct_pkg: shared types for the piecewise linear curve table
// word layouts, op codes, control types between the cells and the top level
// ----------------------------------------------------------------------------
package plct_pkg;

  localparam int unsigned MaxPoints = 32;
  localparam int unsigned CntW      = $clog2(MaxPoints + 1);
  localparam int unsigned IdxW      = $clog2(MaxPoints);

  typedef enum logic [1:0] {
    OP_SET  = 2'd0,
    OP_DEL  = 2'd1,
    OP_EVAL = 2'd2,
    OP_NONE = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] position;
    logic [15:0] point_value;
  } in_word_t;

  typedef struct packed {
    logic [15:0] curve_value;
    logic        hit;
    logic        table_full;
    logic [5:0]  point_count;
  } out_word_t;

  // one point as it lives in a cell
  typedef struct packed {
    logic [15:0] pos;
    logic [15:0] lvl;
  } point_t;

  // row command: every cell acts on it in the same cycle
  typedef enum logic [1:0] {
    ROW_HOLD   = 2'd0,
    ROW_ROTATE = 2'd1,
    ROW_INSERT = 2'd2,
    ROW_REMOVE = 2'd3
  } row_cmd_e;

  typedef struct packed {
    row_cmd_e    cmd;
    point_t      fresh;
  } row_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EDIT,
    ST_DIV,
    ST_OUT
  } state_e;

endpackage
`default_nettype wire

>>> hdl/plct_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plct_cell: one point slot of the table
// rotates toward cell 0 during a scan, shifts up or down on insert and remove
// ----------------------------------------------------------------------------
module plct_cell
  import plct_pkg::*;
(
  input  wire logic     clk_i,
  input  wire row_ctl_t ctl_i,
  input  wire logic     ins_here_i,   // this cell takes the new point
  input  wire logic     ins_above_i,  // this cell lies above the insert slot
  input  wire logic     rem_above_i,  // this cell is at or above the removed slot
  input  wire point_t   lower_i,      // neighbor below
  input  wire point_t   upper_i,      // neighbor above
  output point_t        pt_o
);

  point_t pt_q, pt_d;

  always_comb begin
    pt_d = pt_q;
    case (ctl_i.cmd)
      ROW_ROTATE: pt_d = upper_i;
      ROW_INSERT: begin
        if (ins_here_i) pt_d = ctl_i.fresh;
        else if (ins_above_i) pt_d = lower_i;
      end
      ROW_REMOVE: begin
        if (rem_above_i) pt_d = upper_i;
      end
      default: pt_d = pt_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    pt_q <= pt_d;
  end

  assign pt_o = pt_q;

endmodule
`default_nettype wire

>>> hdl/plct_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plct_div: restoring divider, one quotient bit a cycle
// 32-bit dividend over 16-bit divisor, 16-bit quotient
// ----------------------------------------------------------------------------
module plct_div
  import plct_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [31:0] num_i,
  input  wire logic [15:0] den_i,
  output logic             busy_o,
  output logic [15:0]      quo_o
);

  logic [31:0] num_q, num_d;
  logic [16:0] rem_q, rem_d;
  logic [15:0] den_q, den_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [16:0] trial;
  logic [17:0] diff;

  always_comb begin
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = {rem_q[15:0], num_q[31]};
    diff   = {1'b0, trial} - {2'b00, den_q};
    if (start_i) begin
      num_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = 5'd0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[30:0], ~diff[17]};
      rem_d = diff[17] ? trial : diff[16:0];
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign busy_o = busy_q;
  assign quo_o  = num_q[15:0];

endmodule
`default_nettype wire

>>> hdl/piecewise_linear_curve_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// piecewise_linear_curve_table: sorted control-point table with interpolation
// set / delete / evaluate on up to 32 points held in a row of cells
// ----------------------------------------------------------------------------
//   channel | direction | handshake          | word
//   in      | input     | in_valid_i/ready_o | in_word_t  (op, position, value)
//   out     | output    | out_valid_o/ready_i| out_word_t (value, hit, full, count)
//
// one item at a time. a scan rotates the row of cells once around, cell 0
// being watched for the first point at or above the position; set and
// delete then shift the row in the edit state; an evaluate between points
// runs the 32-step restoring divider. the next word is accepted only once
// the previous result has been taken.
// reset clears the point count, state, output valid and scan step; cell contents are don't-care until used.
// the result sits in an output register; in_ready_o stays low until it is
// taken.
// ----------------------------------------------------------------------------
module piecewise_linear_curve_table
  import plct_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_word_t  in_word_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_word_t      out_word_o
);

  state_e state_q, state_d;
  in_word_t item_q, item_d;
  logic [CntW-1:0] count_q, count_d;
  logic [IdxW-1:0] step_q, step_d;       // rotation step, equals cell index seen
  logic [CntW-1:0] idx_q, idx_d;         // index of the first point >= position, count if none
  logic            found_q, found_d;     // first point >= position located
  logic            exact_q, exact_d;
  point_t          prev_q, prev_d;       // point just below idx
  point_t          next_q, next_d;       // point at idx
  point_t          last_q, last_d;       // highest valid point
  out_word_t       res_q, res_d;
  logic            ov_q, ov_d;
  logic            neg_q, neg_d;
  logic            div_go;
  logic [31:0]     div_num;
  logic [15:0]     div_den;
  logic            div_busy;
  logic [15:0]     div_quo;
  row_ctl_t        ctl;
  point_t          pts [MaxPoints];
  logic [15:0]     dv;
  logic [15:0]     off;
  logic            edit_overwrite;

  // an overwrite reuses the insert command with only the matching cell
  // selected, the cells above it stay where they are
  assign edit_overwrite = (state_q == ST_EDIT) && exact_q &&
                          (op_e'(item_q.op) == OP_SET);

  // ---- row of cells, cell 0 at the bottom, rotate brings cell i+1 down ----
  for (genvar g = 0; g < MaxPoints; g++) begin : g_cell
    localparam logic [CntW-1:0] GIdx = CntW'(g);
    plct_cell u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .ins_here_i  (GIdx == idx_q),
      .ins_above_i ((GIdx > idx_q) && !edit_overwrite),
      .rem_above_i (GIdx >= idx_q),
      .lower_i     (pts[(g + MaxPoints - 1) % MaxPoints]),
      .upper_i     (pts[(g + 1) % MaxPoints]),
      .pt_o        (pts[g])
    );
  end

  plct_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_go),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .quo_o   (div_quo)
  );

  // operands for the interpolation, taken from the registered neighbors
  assign dv  = (next_q.lvl >= prev_q.lvl) ? next_q.lvl - prev_q.lvl
                                          : prev_q.lvl - next_q.lvl;
  assign off = item_q.position - prev_q.pos;
  assign div_num = {16'd0, dv} * {16'd0, off};
  assign div_den = next_q.pos - prev_q.pos;

  always_comb begin
    state_d   = state_q;
    item_d    = item_q;
    count_d   = count_q;
    step_d    = step_q;
    idx_d     = idx_q;
    found_d   = found_q;
    exact_d   = exact_q;
    prev_d    = prev_q;
    next_d    = next_q;
    last_d    = last_q;
    res_d     = res_q;
    ov_d      = ov_q;
    neg_d     = neg_q;
    div_go    = 1'b0;
    ctl.cmd   = ROW_HOLD;
    ctl.fresh = '{pos: item_q.position, lvl: item_q.point_value};
    in_ready_o = 1'b0;

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          item_d  = in_word_i;
          step_d  = '0;
          idx_d   = count_q;
          found_d = 1'b0;
          exact_d = 1'b0;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // cell 0 now holds original entry step_q
        ctl.cmd = ROW_ROTATE;
        if ({1'b0, step_q} < count_q) begin
          if (!found_q) begin
            if (pts[0].pos >= item_q.position) begin
              found_d = 1'b1;
              idx_d   = {1'b0, step_q};
              next_d  = pts[0];
              exact_d = (pts[0].pos == item_q.position);
            end else begin
              prev_d = pts[0];
            end
          end
          last_d = pts[0];
        end
        step_d = step_q + IdxW'(1);
        if (step_q == IdxW'(MaxPoints - 1)) state_d = ST_EDIT;
      end
      ST_EDIT: begin
        res_d = '0;
        state_d = ST_OUT;
        case (op_e'(item_q.op))
          OP_SET: begin
            if (exact_q) begin
              ctl.cmd   = ROW_INSERT;   // overwrite in place: only slot idx
              res_d.hit = 1'b1;
            end else if (count_q >= CntW'(MaxPoints)) begin
              res_d.table_full = 1'b1;
            end else begin
              ctl.cmd = ROW_INSERT;
              count_d = count_q + CntW'(1);
            end
          end
          OP_DEL: begin
            if (exact_q) begin
              ctl.cmd   = ROW_REMOVE;
              count_d   = count_q - CntW'(1);
              res_d.hit = 1'b1;
            end
          end
          OP_EVAL: begin
            if (count_q == '0) res_d.curve_value = '0;
            else if (exact_q) begin
              res_d.curve_value = next_q.lvl;
              res_d.hit = 1'b1;
            end else if (!found_q) res_d.curve_value = last_q.lvl;
            else if (idx_q == '0) res_d.curve_value = next_q.lvl;
            else begin
              div_go  = 1'b1;
              neg_d   = next_q.lvl < prev_q.lvl;
              state_d = ST_DIV;
            end
          end
          default: res_d = '0;
        endcase
        res_d.point_count = count_d;
      end
      ST_DIV: begin
        if (!div_busy) begin
          res_d.curve_value = neg_q ? prev_q.lvl - div_quo : prev_q.lvl + div_quo;
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!ov_q) ov_d = 1'b1;
        else if (out_ready_i) begin
          ov_d    = 1'b0;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      ov_q    <= 1'b0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ov_q    <= ov_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q  <= item_d;
    idx_q   <= idx_d;
    found_q <= found_d;
    exact_q <= exact_d;
    prev_q  <= prev_d;
    next_q  <= next_d;
    last_q  <= last_d;
    res_q   <= res_d;
    neg_q   <= neg_d;
  end

  assign out_valid_o = ov_q;
  assign out_word_o  = res_q;

  // ---- checks ----
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxPoints))
    else $error("point count above capacity");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (state_q == ST_OUT))
    else $error("result shown outside output state");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_busy |-> (state_q == ST_DIV || state_q == ST_EDIT))
    else $error("divider running outside evaluate");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    edit_overwrite |=> (count_q == $past(count_q)))
    else $error("overwrite changed point count");

endmodule
`default_nettype wire
